// ===== src/conv_unroll_index_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// conv_unroll_index_generator_core_defines.svh
// Assertion macros used by the checker of the index generator.
// ----------------------------------------------------------------------------
`ifndef CONV_UNROLL_INDEX_GENERATOR_CORE_DEFINES_SVH
`define CONV_UNROLL_INDEX_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, inactive while reset is asserted.
`define CUIG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define CUIG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define CUIG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cuig_pkg.sv =====
// ----------------------------------------------------------------------------
// cuig_pkg
// Types and constants of the unrolled convolution index generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cuig_pkg;

    localparam int IDX_W    = 10;
    localparam int CH_W     = 4;
    localparam int TAP_W    = 3;
    localparam int KSIZE_W  = 3;
    localparam int SIDE_W   = 4;
    localparam int ACC_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIDE  = 1'b1;

    // Operands of the shared multiply-add unit: y = a * b + c.
    typedef struct packed {
        logic signed [4:0]       a;
        logic signed [7:0]       b;
        logic signed [ACC_W-1:0] c;
    } t_mac_req;

endpackage

`default_nettype wire

// ===== src/cuig_mac.sv =====
// ----------------------------------------------------------------------------
// cuig_mac
// Shared signed multiply-add unit used by the setup sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cuig_mac
    import cuig_pkg::*;
(
    input  wire t_mac_req              i_req,
    output logic signed [ACC_W-1:0]    o_y
);

    logic signed [12:0] prod;
    logic signed [12:0] sum;

    assign prod = i_req.a * i_req.b;
    assign sum  = prod + 13'(i_req.c);
    assign o_y  = sum[ACC_W-1:0];

endmodule

`default_nettype wire

// ===== src/conv_unroll_index_generator_core.sv =====
// ----------------------------------------------------------------------------
// conv_unroll_index_generator_core
// Emits the unrolled (im2col, same padding) weight-matrix positions of one
// kernel weight.
// ----------------------------------------------------------------------------
// Each input transfer names one kernel weight (output channel, input channel,
// kernel row, kernel column). The block walks every pixel of the square
// side x side image in raster order, shifts it by the weight's offset from the
// kernel center, and for each shifted position that stays inside the image it
// sends one output transfer holding the matrix row (out_channel*side*side +
// pixel) and matrix column (in_channel*side*side + shifted pixel); tlast marks
// the final pair. A weight with no valid pixel, or an image side of zero,
// produces no output. For each weight, a single shared multiply-add unit
// first forms side*side and both index bases in the setup states (ST_AREA,
// ST_ROW, ST_COL0, ST_COL1); the walk then visits the side*side pixels in
// turn, holding while a valid pair waits on a full, stalled output register.
// With an image side of zero the block stays idle and takes a weight every
// cycle. The input is not ready while a weight is being worked on; a finished
// pair may still wait in the output register while the next weight is
// accepted. Configuration writes are always accepted and are meant to be
// issued only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module conv_unroll_index_generator_core
    import cuig_pkg::*;
#(
    parameter int MAX_SIDE   = 8,
    parameter int MAX_KERNEL = 7
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,

    // Configuration write channel.
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DAT_W-1:0]  i_cfg_data,

    // Weight input stream.
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // [3:0] out_channel, [7:4] in_channel, [10:8] tap_row, [13:11] tap_col,
    // [15:14] zero
    input  wire [15:0]           s_axis_tdata,

    // Index pair output stream.
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // [9:0] matrix_row, [19:10] matrix_col, [23:20] zero
    output logic [23:0]          m_axis_tdata,
    output logic                 m_axis_tlast
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_AREA = 3'd1;
    localparam logic [2:0] ST_ROW  = 3'd2;
    localparam logic [2:0] ST_COL0 = 3'd3;
    localparam logic [2:0] ST_COL1 = 3'd4;
    localparam logic [2:0] ST_WALK = 3'd5;

    logic [2:0]              r_state;
    logic [2:0]              n_state;

    logic [KSIZE_W-1:0]      r_cfg_ksize;
    logic [SIDE_W-1:0]       r_cfg_side;

    // Latched weight and geometry.
    logic [CH_W-1:0]         r_t;
    logic [CH_W-1:0]         r_s;
    logic signed [4:0]       r_roff;
    logic signed [4:0]       r_coff;
    logic [SIDE_W-1:0]       r_side;
    logic [6:0]              r_area;

    // Running indices and pixel counters of the walk.
    logic [IDX_W-1:0]        r_row_idx;
    logic signed [ACC_W-1:0] r_col_idx;
    logic [2:0]              r_r;
    logic [2:0]              r_c;

    // Output register.
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_row;
    logic [IDX_W-1:0]        r_out_col;
    logic                    r_out_last;

    t_mac_req                mac_req;
    logic signed [ACC_W-1:0] mac_y;

    logic                    in_xfer;
    logic [SIDE_W-1:0]       side_sat;
    logic [3:0]              ksize_sat;
    logic [2:0]              centre;
    logic signed [4:0]       roff_in;
    logic signed [4:0]       coff_in;

    logic signed [4:0]       side_s;
    logic [SIDE_W-1:0]       side_m1;
    logic signed [4:0]       nr;
    logic signed [4:0]       nc;
    logic signed [4:0]       lim_r;
    logic signed [4:0]       lim_c;
    logic                    pix_ok;
    logic                    pix_last;
    logic                    out_load;
    logic                    advance;
    logic                    col_end;
    logic                    walk_end;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Saturate the configured geometry and derive the tap offsets.
    assign side_sat  = (r_cfg_side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r_cfg_side;
    assign ksize_sat = ({1'b0, r_cfg_ksize} > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL)
                                                              : {1'b0, r_cfg_ksize};
    assign centre    = ksize_sat[3:1];
    assign roff_in   = $signed({2'b00, s_axis_tdata[10:8]}) - $signed({2'b00, centre});
    assign coff_in   = $signed({2'b00, s_axis_tdata[13:11]}) - $signed({2'b00, centre});

    // Setup schedule of the shared multiply-add unit:
    // area = side*side, row base = t*area, col base = s*area + coff + roff*side.
    always_comb begin
        mac_req = '0;
        case (r_state)
            ST_AREA: begin
                mac_req.a = $signed({1'b0, r_side});
                mac_req.b = $signed({4'b0000, r_side});
            end
            ST_ROW: begin
                mac_req.a = $signed({1'b0, r_t});
                mac_req.b = $signed({1'b0, r_area});
            end
            ST_COL0: begin
                mac_req.a = $signed({1'b0, r_s});
                mac_req.b = $signed({1'b0, r_area});
                mac_req.c = ACC_W'(r_coff);
            end
            ST_COL1: begin
                mac_req.a = r_roff;
                mac_req.b = $signed({4'b0000, r_side});
                mac_req.c = r_col_idx;
            end
            default: begin
                mac_req = '0;
            end
        endcase
    end

    cuig_mac u_mac (
        .i_req (mac_req),
        .o_y   (mac_y)
    );

    // Pixel walk: the shifted position is valid when it lies in the image.
    // The final valid pixel sits at the largest valid row and column.
    assign side_s   = $signed({1'b0, r_side});
    assign side_m1  = r_side - 4'd1;
    assign nr       = $signed({2'b00, r_r}) + r_roff;
    assign nc       = $signed({2'b00, r_c}) + r_coff;
    assign lim_r    = side_s - 5'sd1 - (r_roff[4] ? 5'sd0 : r_roff);
    assign lim_c    = side_s - 5'sd1 - (r_coff[4] ? 5'sd0 : r_coff);
    assign pix_ok   = !nr[4] && (nr < side_s) && !nc[4] && (nc < side_s);
    assign pix_last = ($signed({2'b00, r_r}) == lim_r) && ($signed({2'b00, r_c}) == lim_c);
    assign out_load = (r_state == ST_WALK) && pix_ok && (!r_out_valid || m_axis_tready);
    assign advance  = (r_state == ST_WALK) && (!pix_ok || out_load);
    assign col_end  = ({1'b0, r_c} == side_m1);
    assign walk_end = col_end && ({1'b0, r_r} == side_m1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (side_sat != '0)) begin
                    n_state = ST_AREA;
                end
            end
            ST_AREA: n_state = ST_ROW;
            ST_ROW:  n_state = ST_COL0;
            ST_COL0: n_state = ST_COL1;
            ST_COL1: n_state = ST_WALK;
            ST_WALK: begin
                if (advance && walk_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_ksize <= KSIZE_W'(3);
            r_cfg_side  <= SIDE_W'(8);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KERNEL_SIZE: r_cfg_ksize <= i_cfg_data[KSIZE_W-1:0];
                    CFG_IMAGE_SIDE:  r_cfg_side  <= i_cfg_data[SIDE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_t    <= s_axis_tdata[3:0];
            r_s    <= s_axis_tdata[7:4];
            r_roff <= roff_in;
            r_coff <= coff_in;
            r_side <= side_sat;
        end
        case (r_state)
            ST_AREA: r_area    <= mac_y[6:0];
            ST_ROW:  r_row_idx <= mac_y[IDX_W-1:0];
            ST_COL0: r_col_idx <= mac_y;
            ST_COL1: begin
                r_col_idx <= mac_y;
                r_r       <= 3'd0;
                r_c       <= 3'd0;
            end
            ST_WALK: begin
                if (advance) begin
                    r_row_idx <= r_row_idx + 10'd1;
                    r_col_idx <= r_col_idx + 12'sd1;
                    if (col_end) begin
                        r_c <= 3'd0;
                        r_r <= r_r + 3'd1;
                    end else begin
                        r_c <= r_c + 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_row  <= r_row_idx;
            r_out_col  <= r_col_idx[IDX_W-1:0];
            r_out_last <= pix_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_col, r_out_row};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== src/cuig_checker.sv =====
// ----------------------------------------------------------------------------
// cuig_checker
// Port-level assertions for the unrolled convolution index generator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "conv_unroll_index_generator_core_defines.svh"

module cuig_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire        m_axis_tlast
);

    // A stalled pair stays offered and unchanged.
    `CUIG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output pair changed")

    // While a pair that is not the last is offered, the walk is still running.
    `CUIG_ASSERT_IMPL(a_busy_mid_run, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready before the run ended")

    // Reset empties the output register.
    `CUIG_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")

endmodule

bind conv_unroll_index_generator_core cuig_checker u_cuig_checker (.*);

`default_nettype wire

// ===== tb/tb_conv_unroll_index_generator_core.sv =====
// ----------------------------------------------------------------------------
// tb_conv_unroll_index_generator_core
// Self-checking testbench for the unrolled convolution index generator.
// ----------------------------------------------------------------------------
// Weights are sent on the input stream. A behavioral model in this file turns
// each accepted weight into the list of (matrix row, matrix column, last)
// pairs it should produce, given the current kernel size and image side.
// A monitor compares every output transfer against the oldest pending pair.
// The run has a directed part covering field extremes, kernel sizes of zero
// and seven, image sides of zero, one and above the maximum, and taps beyond
// the kernel. It then runs phases of random weights under different settings.
// Both streams idle at random, except for one phase where neither side does.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_conv_unroll_index_generator_core
    import cuig_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles the block may still be busy on a weight that makes no pairs:
    // the setup states plus a full 8 x 8 walk, with some margin.
    localparam int DRAIN_CYCLES = 80;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_SIDE_TB  = 8;

    // One expected output transfer.
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_index_pair;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;
    logic                 m_axis_tlast;

    conv_unroll_index_generator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Model copy of the two registers, updated on each accepted write.
    logic [KSIZE_W-1:0] kernel_size_q;
    logic [SIDE_W-1:0]  image_side_q;

    t_index_pair pending_pairs[$];

    int src_idle_pct;
    int sink_idle_pct;
    int error_count;
    int weight_count;
    int pair_count;
    int write_count;
    int quiet_cycles;

    // 4 ns clock, driven with blocking assignments so that every process
    // woken on the rising edge still sees the values from before the edge.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Works out every pair that one weight produces under the current
    // settings and queues them in output order. The pair found last is held
    // back one step so that it can be queued with its last flag set.
    function automatic void queue_weight_pairs(input logic [CH_W-1:0] oc,
                                               input logic [CH_W-1:0] ic,
                                               input logic [TAP_W-1:0] tr,
                                               input logic [TAP_W-1:0] tc);
        int side;
        int area;
        int center;
        int nr;
        int nc;
        bit have_held;
        t_index_pair held;
        side = (image_side_q > MAX_SIDE_TB) ? MAX_SIDE_TB : int'(image_side_q);
        area = side * side;
        center = int'(kernel_size_q) / 2;
        have_held = 1'b0;
        held = '0;
        for (int p = 0; p < area; p++) begin
            nr = p / side + int'(tr) - center;
            nc = p % side + int'(tc) - center;
            if (nr >= 0 && nr < side && nc >= 0 && nc < side) begin
                if (have_held) begin
                    pending_pairs = {pending_pairs, held};
                end
                held.row  = IDX_W'(int'(oc) * area + p);
                held.col  = IDX_W'(int'(ic) * area + nr * side + nc);
                held.last = 1'b0;
                have_held = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            pending_pairs = {pending_pairs, held};
        end
    endfunction

    // The sink side stalls at random; the pattern is redrawn every cycle.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Output monitor: every transfer must match the oldest pending pair.
    always @(posedge i_clk) begin
        t_index_pair want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pairs.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transfer row %0d col %0d last %0b", $time,
                         m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tlast);
            end else begin
                want = pending_pairs.pop_front();
                pair_count++;
                if (m_axis_tdata[9:0] !== want.row) begin
                    error_count++;
                    $display("%0t: matrix_row expected %0d actual %0d", $time,
                             want.row, m_axis_tdata[9:0]);
                end
                if (m_axis_tdata[19:10] !== want.col) begin
                    error_count++;
                    $display("%0t: matrix_col expected %0d actual %0d", $time,
                             want.col, m_axis_tdata[19:10]);
                end
                if (m_axis_tlast !== want.last) begin
                    error_count++;
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: a long run of cycles without any transfer means a hang.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // All tasks below start and end just after a falling edge.

    // Writes one register and mirrors it into the model once accepted.
    // Valid is left high afterwards; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_KERNEL_SIZE: kernel_size_q = data[KSIZE_W-1:0];
            CFG_IMAGE_SIDE:  image_side_q  = data[SIDE_W-1:0];
            default: ;
        endcase
        write_count++;
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input int ksize, input int side);
        write_reg(CFG_KERNEL_SIZE, CFG_DAT_W'(ksize));
        write_reg(CFG_IMAGE_SIDE, CFG_DAT_W'(side));
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one weight, after a random number of idle cycles. Valid stays
    // high after the transfer so that back-to-back weights need no toggle.
    task automatic send_weight(input logic [CH_W-1:0] oc, input logic [CH_W-1:0] ic,
                               input logic [TAP_W-1:0] tr, input logic [TAP_W-1:0] tc);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, tc, tr, ic, oc};
        do @(posedge i_clk); while (!s_axis_tready);
        queue_weight_pairs(oc, ic, tr, tc);
        weight_count++;
        @(negedge i_clk);
    endtask

    // Waits until every pending pair has arrived, then lets the block finish
    // any weight that produces nothing, so that it is idle afterwards.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Field extremes and taps beyond the kernel under the reset settings
    // (kernel 3, image side 8).
    task automatic test_reset_settings();
        send_weight(4'd0, 4'd0, 3'd1, 3'd1);
        send_weight(4'd15, 4'd15, 3'd0, 3'd0);
        send_weight(4'd15, 4'd0, 3'd2, 3'd2);
        send_weight(4'd0, 4'd15, 3'd7, 3'd7);
        send_weight(4'd5, 4'd10, 3'd0, 3'd2);
        send_weight(4'd10, 4'd5, 3'd6, 3'd1);
        drain_block();
    endtask

    // Kernel of zero (the tap itself is the offset) and the largest kernel.
    task automatic test_kernel_extremes();
        set_geometry(0, 8);
        send_weight(4'd3, 4'd4, 3'd0, 3'd0);
        send_weight(4'd1, 4'd2, 3'd7, 3'd7);
        send_weight(4'd12, 4'd9, 3'd2, 3'd5);
        drain_block();
        set_geometry(7, 8);
        send_weight(4'd15, 4'd15, 3'd3, 3'd3);
        send_weight(4'd6, 4'd7, 3'd0, 3'd6);
        drain_block();
    endtask

    // Image sides of zero and one, a side above the maximum that saturates,
    // and a small side where one weight fits only once.
    task automatic test_image_extremes();
        set_geometry(3, 0);
        send_weight(4'd15, 4'd15, 3'd1, 3'd1);
        drain_block();
        set_geometry(7, 1);
        send_weight(4'd9, 4'd6, 3'd3, 3'd3);
        send_weight(4'd9, 4'd6, 3'd0, 3'd3);
        drain_block();
        set_geometry(5, 15);
        send_weight(4'd15, 4'd15, 3'd2, 3'd2);
        send_weight(4'd7, 4'd8, 3'd4, 3'd0);
        drain_block();
        set_geometry(3, 2);
        send_weight(4'd15, 4'd15, 3'd1, 3'd1);
        send_weight(4'd8, 4'd3, 3'd2, 3'd0);
        drain_block();
    endtask

    // Random phases. The first ones pin the extreme settings; the rest draw
    // the settings at random. Most taps lie inside the kernel, the rest take
    // any 3-bit value. One phase runs with no idling on either side.
    task automatic test_random_phases();
        int ksize;
        int side;
        logic [TAP_W-1:0] tr;
        logic [TAP_W-1:0] tc;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin ksize = 7; side = 8;  end
                1: begin ksize = 1; side = 1;  end
                2: begin ksize = 0; side = 15; end
                3: begin ksize = 3; side = 8;  end
                default: begin
                    ksize = $urandom_range(7);
                    side  = $urandom_range(15);
                end
            endcase
            set_geometry(ksize, side);
            src_idle_pct  = (ph == 5) ? 0 : 12;
            sink_idle_pct = (ph == 5) ? 0 : 12;
            for (int n = 0; n < 10; n++) begin
                if (ksize > 0 && $urandom_range(99) < 85) begin
                    tr = TAP_W'($urandom_range(ksize - 1));
                    tc = TAP_W'($urandom_range(ksize - 1));
                end else begin
                    tr = TAP_W'($urandom_range(7));
                    tc = TAP_W'($urandom_range(7));
                end
                send_weight(CH_W'($urandom_range(15)), CH_W'($urandom_range(15)), tr, tc);
            end
            drain_block();
        end
        src_idle_pct  = 12;
        sink_idle_pct = 12;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        kernel_size_q = KSIZE_W'(3);
        image_side_q  = SIDE_W'(8);
        src_idle_pct  = 12;
        sink_idle_pct = 12;
        error_count   = 0;
        weight_count  = 0;
        pair_count    = 0;
        write_count   = 0;
        quiet_cycles  = 0;

        // Reset is held, then released on a falling edge.
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_settings();
        test_kernel_extremes();
        test_image_extremes();
        test_random_phases();

        // drain_block already waited out the last weight's walk.
        drain_block();

        $display("Covered %0d weights, %0d index pairs and %0d register writes,",
                 weight_count, pair_count, write_count);
        $display("with kernels 0 to 7 and image sides from 0 up past the maximum.");
        if (error_count == 0 && pending_pairs.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/cuig_pkg.sv
src/cuig_mac.sv
src/conv_unroll_index_generator_core.sv
src/cuig_checker.sv
tb/tb_conv_unroll_index_generator_core.sv
